// ----- sv/pbpc_pkg.sv -----
// Package: widths, constants and shared types for the power-bisector clipper
`timescale 1ns / 1ps
`default_nettype none
package pbpc_pkg;
	localparam int FRAC_BITS = 18;
	localparam int C_W = 19;
	localparam int W_W = 21;
	localparam int F_W = ((FRAC_BITS + 22 > 41) ? FRAC_BITS + 22 : 41) + 1;
	localparam int D_W = F_W + 1;
	localparam int R_W = D_W + 2;
	localparam int Q_W = C_W + 1;
	localparam int COORD_MAX = 262144;

	typedef logic [C_W-1:0] coord_t;

	typedef struct packed {
		logic           start;
		coord_t         a;
		coord_t         b;
		logic [D_W-1:0] ua;
		logic [D_W-1:0] ud;
	} lerp_req_t;

	typedef struct packed {
		logic   done;
		coord_t res;
	} lerp_rsp_t;
endpackage
`default_nettype wire

// ----- sv/pbpc_vtx_if.sv -----
// Interface: vertex input channel
`timescale 1ns / 1ps
`default_nettype none
interface pbpc_vtx_if;
	import pbpc_pkg::*;
	logic   valid;
	logic   ready;
	coord_t vertex_x;
	coord_t vertex_y;
	logic   last_vertex;
	modport source(output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink(input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface
`default_nettype wire

// ----- sv/pbpc_res_if.sv -----
// Interface: clipped vertex result channel
`timescale 1ns / 1ps
`default_nettype none
interface pbpc_res_if;
	import pbpc_pkg::*;
	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	logic   vertex_valid;
	logic   out_last;
	modport source(output valid, output out_x, output out_y, output vertex_valid,
		output out_last, input ready);
	modport sink(input valid, input out_x, input out_y, input vertex_valid,
		input out_last, output ready);
endinterface
`default_nettype wire

// ----- sv/pbpc_lerp.sv -----
// Iterative crossing interpolator: one coordinate, one shift/subtract step per cycle
`timescale 1ns / 1ps
`default_nettype none
module pbpc_lerp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pbpc_pkg::lerp_req_t req,
	output pbpc_pkg::lerp_rsp_t rsp
);
	import pbpc_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ADD  = 3'd1;
	localparam logic [2:0] PH_SUB1 = 3'd2;
	localparam logic [2:0] PH_SUB2 = 3'd3;
	localparam logic [2:0] PH_RND  = 3'd4;
	localparam logic [2:0] PH_FIN  = 3'd5;

	logic [2:0]     ph_q;
	logic [4:0]     bit_q;
	logic [R_W-1:0] r_q;
	logic [Q_W-1:0] q_q;
	logic           done_q;
	coord_t         res_q;

	logic           neg;
	coord_t         mag;
	logic [R_W-1:0] ud_ext;
	logic [Q_W-1:0] qc;
	logic [C_W+1:0] sum;

	// distance along the edge and its direction
	assign neg    = req.b < req.a;
	assign mag    = neg ? (req.a - req.b) : (req.b - req.a);
	assign ud_ext = R_W'(req.ud);
	assign qc     = (q_q > Q_W'(mag)) ? Q_W'(mag) : q_q;
	assign sum    = neg ? ((C_W+2)'(req.a) - (C_W+2)'(qc)) : ((C_W+2)'(req.a) + (C_W+2)'(qc));

	// long division of |fa|*mag by |den|; each quotient bit passes the add phase, then both subtract phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (req.start) begin
						r_q   <= '0;
						q_q   <= '0;
						bit_q <= 5'(C_W - 1);
						ph_q  <= PH_ADD;
					end
				end
				PH_ADD: begin
					r_q  <= {r_q[R_W-2:0], 1'b0} + (mag[bit_q] ? R_W'(req.ua) : '0);
					q_q  <= {q_q[Q_W-2:0], 1'b0};
					ph_q <= PH_SUB1;
				end
				PH_SUB1: begin
					if (r_q >= ud_ext) begin
						r_q <= r_q - ud_ext;
						q_q <= q_q + 1'b1;
					end
					ph_q <= PH_SUB2;
				end
				PH_SUB2: begin
					if (r_q >= ud_ext) begin
						r_q <= r_q - ud_ext;
						q_q <= q_q + 1'b1;
					end
					if (bit_q == '0) ph_q <= PH_RND;
					else begin
						bit_q <= bit_q - 1'b1;
						ph_q  <= PH_ADD;
					end
				end
				PH_RND: begin
					// round to nearest, tie away from A
					if ({r_q[R_W-2:0], 1'b0} >= ud_ext) q_q <= q_q + 1'b1;
					ph_q <= PH_FIN;
				end
				PH_FIN: begin
					res_q  <= (sum > (C_W+2)'(COORD_MAX)) ? C_W'(COORD_MAX) : C_W'(sum);
					done_q <= 1'b1;
					ph_q   <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;
endmodule
`default_nettype wire

// ----- sv/power_bisector_polygon_clip_top.sv -----
// Top level: power-bisector polygon clipper with sequencer, squarer and register port
//
// Polygon vertices arrive on the vtx channel (valid/ready), last_vertex on the final one.
// Clipped vertices leave on the res channel; out_last marks the final result of a
// polygon, and a polygon that clips away entirely gives one transfer with
// vertex_valid = 0. The closing edge is handled with the last vertex, so the output
// starts with the results of the first edge.
// Sites and weights are written through the APB port (one register per word); the user
// must write them only while the block is idle, which the block itself does not enforce.
// Each vertex takes one transfer at a time: ready is high only between items. The
// power difference is formed on the shared squarer and accumulator, and every crossing
// is found in the iterative interpolator for two coordinates, X and then Y. A stalled
// receiver holds the result register and the sequencer waits. Reset clears the sites,
// weights, sequencer state and the stored previous and first vertices.
`timescale 1ns / 1ps
`default_nettype none
module power_bisector_polygon_clip_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	pbpc_vtx_if.sink    vtx,
	pbpc_res_if.source  res
);
	import pbpc_pkg::*;

	localparam logic [2:0] REG_SITE_X  = 3'd0;
	localparam logic [2:0] REG_SITE_Y  = 3'd1;
	localparam logic [2:0] REG_OTHER_X = 3'd2;
	localparam logic [2:0] REG_OTHER_Y = 3'd3;
	localparam logic [2:0] REG_SITE_W  = 3'd4;
	localparam logic [2:0] REG_OTHER_W = 3'd5;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_ACC  = 4'd2;
	localparam logic [3:0] S_SLOT = 4'd3;
	localparam logic [3:0] S_PREP = 4'd4;
	localparam logic [3:0] S_CX   = 4'd5;
	localparam logic [3:0] S_CY   = 4'd6;
	localparam logic [3:0] S_EMIT = 4'd7;

	localparam logic [2:0] SL_CROSS1 = 3'd0;
	localparam logic [2:0] SL_VERT1  = 3'd1;
	localparam logic [2:0] SL_CROSS2 = 3'd2;
	localparam logic [2:0] SL_VERT2  = 3'd3;
	localparam logic [2:0] SL_MARK   = 3'd4;
	localparam logic [2:0] SL_END    = 3'd5;

	// configuration
	coord_t           site_x_q, site_y_q, other_x_q, other_y_q;
	logic [W_W-1:0]   site_w_q, other_w_q;

	// polygon state
	coord_t           vx_q, vy_q, prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic signed [F_W-1:0] acc_q, prev_f_q, first_f_q;
	logic             last_q, mid_q, any_q, vin_q, prev_in_q, first_in_q;
	logic [3:0]       st_q;
	logic [1:0]       k_q;
	logic [2:0]       slot_q;
	logic [2*C_W-1:0] prod_q;
	logic [D_W-1:0]   ua_q, ud_q;
	logic             cy_q, start_q;
	coord_t           ox_q, oy_q;
	logic             ovalid_q;

	// result register
	logic             rv_q;
	coord_t           rx_q, ry_q;
	logic             rvv_q, rlast_q;

	logic [2:0]       wa;
	logic             wr;
	logic signed [W_W:0]   wdiff;
	logic signed [F_W-1:0] acc_init;
	logic signed [F_W-1:0] prod_ext;
	coord_t           mx, my, sq_in;
	logic [4:0]       pres;
	logic             is_last;
	logic             cross2;
	logic signed [D_W-1:0] fa, fb, den;
	logic             load_res;
	lerp_req_t        lreq;
	lerp_rsp_t        lrsp;

	// APB register file
	assign pready = 1'b1;
	assign wa     = paddr[4:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_x_q  <= '0;
			site_y_q  <= '0;
			other_x_q <= '0;
			other_y_q <= '0;
			site_w_q  <= '0;
			other_w_q <= '0;
		end else if (wr) begin
			case (wa)
				REG_SITE_X:  site_x_q  <= pwdata[C_W-1:0];
				REG_SITE_Y:  site_y_q  <= pwdata[C_W-1:0];
				REG_OTHER_X: other_x_q <= pwdata[C_W-1:0];
				REG_OTHER_Y: other_y_q <= pwdata[C_W-1:0];
				REG_SITE_W:  site_w_q  <= pwdata[W_W-1:0];
				REG_OTHER_W: other_w_q <= pwdata[W_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wa)
			REG_SITE_X:  prdata = 32'(site_x_q);
			REG_SITE_Y:  prdata = 32'(site_y_q);
			REG_OTHER_X: prdata = 32'(other_x_q);
			REG_OTHER_Y: prdata = 32'(other_y_q);
			REG_SITE_W:  prdata = 32'(site_w_q);
			REG_OTHER_W: prdata = 32'(other_w_q);
			default:     prdata = '0;
		endcase
	end

	// weight term and squarer operand
	assign wdiff    = (W_W+1)'($signed(site_w_q)) - (W_W+1)'($signed(other_w_q));
	assign acc_init = -(F_W'(wdiff) <<< FRAC_BITS);
	assign prod_ext = $signed(F_W'(prod_q));

	always_comb begin
		case (k_q)
			2'd0:    begin mx = vx_q; my = site_x_q;  end
			2'd1:    begin mx = vy_q; my = site_y_q;  end
			2'd2:    begin mx = vx_q; my = other_x_q; end
			default: begin mx = vy_q; my = other_y_q; end
		endcase
		sq_in = (mx >= my) ? (mx - my) : (my - mx);
	end

	// which results this vertex gives: crossing, vertex, closing crossing, first vertex, empty mark
	assign pres[0] = mid_q && (prev_in_q != vin_q);
	assign pres[1] = mid_q && vin_q;
	assign pres[2] = last_q && (vin_q != first_in_q);
	assign pres[3] = last_q && first_in_q;
	assign pres[4] = last_q && !any_q;

	always_comb begin
		case (slot_q)
			SL_CROSS1: is_last = last_q && !pres[1] && !pres[2] && !pres[3];
			SL_VERT1:  is_last = last_q && !pres[2] && !pres[3];
			SL_CROSS2: is_last = last_q && !pres[3];
			default:   is_last = 1'b1;
		endcase
	end

	// crossing operands
	assign cross2 = (slot_q == SL_CROSS2);
	assign fa     = D_W'(cross2 ? acc_q : prev_f_q);
	assign fb     = D_W'(cross2 ? first_f_q : acc_q);
	assign den    = fb - fa;

	assign lreq.start = start_q;
	assign lreq.a     = cross2 ? (cy_q ? vy_q : vx_q) : (cy_q ? prev_y_q : prev_x_q);
	assign lreq.b     = cross2 ? (cy_q ? first_y_q : first_x_q) : (cy_q ? vy_q : vx_q);
	assign lreq.ua    = ua_q;
	assign lreq.ud    = ud_q;

	pbpc_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lreq),
		.rsp    (lrsp)
	);

	assign load_res  = (st_q == S_EMIT) && (!rv_q || res.ready);
	assign vtx.ready = (st_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			k_q        <= '0;
			slot_q     <= SL_CROSS1;
			mid_q      <= 1'b0;
			last_q     <= 1'b0;
			any_q      <= 1'b0;
			vin_q      <= 1'b0;
			prev_in_q  <= 1'b0;
			first_in_q <= 1'b0;
			cy_q       <= 1'b0;
			start_q    <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_f_q   <= '0;
			first_f_q  <= '0;
		end else begin
			start_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (vtx.valid) begin
						vx_q   <= vtx.vertex_x;
						vy_q   <= vtx.vertex_y;
						last_q <= vtx.last_vertex;
						acc_q  <= acc_init;
						any_q  <= 1'b0;
						k_q    <= '0;
						st_q   <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= sq_in * sq_in;
					st_q   <= S_ACC;
				end
				S_ACC: begin
					if (k_q[1]) acc_q <= acc_q - prod_ext;
					else        acc_q <= acc_q + prod_ext;
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						st_q   <= S_SLOT;
						slot_q <= SL_CROSS1;
					end else st_q <= S_MUL;
				end
				S_SLOT: begin
					if (slot_q == SL_CROSS1 && k_q == 2'd0 && !mid_q) begin
						// first vertex of a polygon opens the closing edge
						first_x_q  <= vx_q;
						first_y_q  <= vy_q;
						first_f_q  <= acc_q;
						first_in_q <= (acc_q <= 0);
					end
					vin_q <= (acc_q <= 0);
					k_q   <= 2'd1;
					if (k_q == 2'd0) begin
						// settle step so the inside flags are current
					end else if (slot_q == SL_END) begin
						mid_q     <= !last_q;
						prev_x_q  <= vx_q;
						prev_y_q  <= vy_q;
						prev_f_q  <= acc_q;
						prev_in_q <= vin_q;
						st_q      <= S_IDLE;
					end else if (!pres[slot_q]) begin
						slot_q <= slot_q + 1'b1;
					end else if (slot_q == SL_CROSS1 || slot_q == SL_CROSS2) begin
						st_q <= S_PREP;
					end else begin
						ox_q     <= (slot_q == SL_VERT1) ? vx_q :
							(slot_q == SL_VERT2) ? first_x_q : '0;
						oy_q     <= (slot_q == SL_VERT1) ? vy_q :
							(slot_q == SL_VERT2) ? first_y_q : '0;
						ovalid_q <= (slot_q != SL_MARK);
						st_q     <= S_EMIT;
					end
				end
				S_PREP: begin
					ua_q    <= fa[D_W-1] ? D_W'(-fa) : D_W'(fa);
					ud_q    <= den[D_W-1] ? D_W'(-den) : D_W'(den);
					cy_q    <= 1'b0;
					start_q <= 1'b1;
					st_q    <= S_CX;
				end
				S_CX: begin
					if (lrsp.done) begin
						ox_q    <= lrsp.res;
						cy_q    <= 1'b1;
						start_q <= 1'b1;
						st_q    <= S_CY;
					end
				end
				S_CY: begin
					if (lrsp.done) begin
						oy_q     <= lrsp.res;
						ovalid_q <= 1'b1;
						st_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load_res) begin
						if (ovalid_q) any_q <= 1'b1;
						slot_q <= slot_q + 1'b1;
						st_q   <= S_SLOT;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (load_res) begin
			rv_q <= 1'b1;
		end else if (res.ready) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			rx_q    <= ox_q;
			ry_q    <= oy_q;
			rvv_q   <= ovalid_q;
			rlast_q <= is_last;
		end
	end

	assign res.valid        = rv_q;
	assign res.out_x        = rx_q;
	assign res.out_y        = ry_q;
	assign res.vertex_valid = rvv_q;
	assign res.out_last     = rlast_q;
endmodule
`default_nettype wire
